// ===== sv/hpq_pkg.sv =====
// Shared types and constants for the binary min-heap priority queue.
// Standalone package; every other file of the block imports it, except hpq_ram.
package hpq_pkg;

  localparam int CAPACITY    = 256;
  localparam int KEY_BITS    = 32;
  localparam int HANDLE_BITS = 9;

  localparam int ADDR_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
  // child index 2*pos+2 can reach 2*CAPACITY
  localparam int CHILD_BITS  = ADDR_BITS + 2;
  localparam int ENTRY_BITS  = KEY_BITS + HANDLE_BITS;
  localparam int STATUS_BITS = 2;

  typedef logic [KEY_BITS-1:0]    key_t;
  typedef logic [HANDLE_BITS-1:0] handle_t;
  typedef logic [ADDR_BITS-1:0]   addr_t;
  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [CHILD_BITS-1:0]  child_t;

  localparam count_t CAP_COUNT = count_t'(CAPACITY);

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    key_t    key;
    handle_t handle;
  } entry_t;

  // which of current, left or right holds the strictly smallest key
  typedef enum logic [1:0] {
    SEL_CUR   = 2'd0,
    SEL_LEFT  = 2'd1,
    SEL_RIGHT = 2'd2
  } cmp_sel_e;

  typedef struct packed {
    key_t cur;
    key_t left;
    key_t right;
    logic left_ok;
    logic right_ok;
  } cmp_req_t;

  typedef struct packed {
    logic   we;
    addr_t  waddr;
    entry_t wdata;
    addr_t  raddr_a;
    addr_t  raddr_b;
  } ram_req_t;

endpackage

// ===== sv/hpq_if.sv =====
// Valid/ready channel interfaces for the heap queue request and response.
// Depends on hpq_pkg.
interface hpq_in_if;
  import hpq_pkg::*;

  logic    valid;
  logic    ready;
  logic    opcode;
  key_t    key;
  handle_t handle;

  modport source (output valid, output opcode, output key, output handle, input ready);
  modport sink   (input valid, input opcode, input key, input handle, output ready);
endinterface

interface hpq_out_if;
  import hpq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  key_t                   min_key;
  handle_t                min_handle;
  count_t                 count;

  modport source (output valid, output status, output min_key, output min_handle,
                  output count, input ready);
  modport sink   (input valid, input status, input min_key, input min_handle,
                  input count, output ready);
endinterface

// ===== sv/hpq_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No package dependencies.
module hpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                         rdata_a,
  output logic [WIDTH-1:0]                         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== sv/hpq_cmp.sv =====
// Shared key compare unit: picks the strictly smallest of current, left, right.
// Ties keep the earlier candidate (current, then left). Depends on hpq_pkg.
module hpq_cmp (
  input  hpq_pkg::cmp_req_t req,
  output hpq_pkg::cmp_sel_e sel
);
  import hpq_pkg::*;

  key_t best;

  always_comb begin
    sel  = SEL_CUR;
    best = req.cur;
    if (req.left_ok && (req.left < best)) begin
      sel  = SEL_LEFT;
      best = req.left;
    end
    if (req.right_ok && (req.right < best)) begin
      sel = SEL_RIGHT;
    end
  end

endmodule

// ===== sv/hpq_ctrl.sv =====
// Heap sequencer: insert sift-up and extract sift-down, one level per cycle,
// plus the response register. Depends on hpq_pkg and hpq_if.
module hpq_ctrl (
  input  logic                clk,
  input  logic                rst,
  hpq_in_if.sink              req,
  hpq_out_if.source           rsp,
  output hpq_pkg::ram_req_t   ram_req,
  input  hpq_pkg::entry_t     rdata_a,
  input  hpq_pkg::entry_t     rdata_b,
  output hpq_pkg::cmp_req_t   cmp_req,
  input  hpq_pkg::cmp_sel_e   cmp_sel
);
  import hpq_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    DECODE,
    INS_CMP,
    INS_FIN,
    EXT_LOAD,
    EXT_CMP,
    RESP
  } state_t;

  state_t  state;
  opcode_e opcode;
  entry_t  item;      // pair being inserted
  entry_t  cur;       // entry sinking from the root
  entry_t  min_q;
  status_e status;
  addr_t   pos;       // current hole
  count_t  count;

  logic                   rsp_valid;
  logic [STATUS_BITS-1:0] rsp_status;
  key_t                   rsp_min_key;
  handle_t                rsp_min_handle;
  count_t                 rsp_count;

  addr_t  parent;
  addr_t  grand;
  count_t cnt_m1;
  child_t left;
  child_t right;
  addr_t  best;
  child_t best_left;
  logic   rsp_load;

  assign parent    = (pos - addr_t'(1)) >> 1;
  assign grand     = (parent - addr_t'(1)) >> 1;
  assign cnt_m1    = count - count_t'(1);
  assign left      = (child_t'(pos) << 1) + child_t'(1);
  assign right     = left + child_t'(1);
  assign best      = (cmp_sel == SEL_RIGHT) ? right[ADDR_BITS-1:0] : left[ADDR_BITS-1:0];
  assign best_left = (child_t'(best) << 1) + child_t'(1);
  assign rsp_load  = (state == RESP) && (!rsp_valid || rsp.ready);

  assign req.ready      = (state == IDLE);
  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.min_key    = rsp_min_key;
  assign rsp.min_handle = rsp_min_handle;
  assign rsp.count      = rsp_count;

  // compare unit inputs: sift-up asks "item < parent", sift-down picks the child
  always_comb begin
    cmp_req.cur      = rdata_a.key;
    cmp_req.left     = item.key;
    cmp_req.right    = rdata_b.key;
    cmp_req.left_ok  = 1'b1;
    cmp_req.right_ok = 1'b0;
    if (state == EXT_CMP) begin
      cmp_req.cur      = cur.key;
      cmp_req.left     = rdata_a.key;
      cmp_req.left_ok  = left < child_t'(count);
      cmp_req.right_ok = right < child_t'(count);
    end
  end

  // memory access per state; the next level's read goes out with this level's write
  always_comb begin
    ram_req.we      = 1'b0;
    ram_req.waddr   = pos;
    ram_req.wdata   = item;
    ram_req.raddr_a = '0;
    ram_req.raddr_b = '0;
    unique case (state)
      DECODE: begin
        if (opcode == OP_INSERT) begin
          if (count == '0) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = '0;
          end else begin
            ram_req.raddr_a = addr_t'(cnt_m1 >> 1);
          end
        end else begin
          ram_req.raddr_a = '0;
          ram_req.raddr_b = addr_t'(cnt_m1);
        end
      end
      INS_CMP: begin
        ram_req.we = 1'b1;
        if (cmp_sel == SEL_LEFT) begin
          ram_req.wdata   = rdata_a;
          ram_req.raddr_a = grand;
        end
      end
      INS_FIN: begin
        ram_req.we = 1'b1;
      end
      EXT_LOAD: begin
        ram_req.raddr_a = addr_t'(1);
        ram_req.raddr_b = addr_t'(2);
      end
      EXT_CMP: begin
        ram_req.we      = 1'b1;
        ram_req.raddr_a = best_left[ADDR_BITS-1:0];
        ram_req.raddr_b = best_left[ADDR_BITS-1:0] + addr_t'(1);
        case (cmp_sel)
          SEL_LEFT:  ram_req.wdata = rdata_a;
          SEL_RIGHT: ram_req.wdata = rdata_b;
          default:   ram_req.wdata = cur;
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid      <= 1'b1;
        rsp_status     <= status;
        rsp_min_key    <= min_q.key;
        rsp_min_handle <= min_q.handle;
        rsp_count      <= count;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (req.valid) begin
            opcode      <= opcode_e'(req.opcode);
            item.key    <= req.key;
            item.handle <= req.handle;
            state       <= DECODE;
          end
        end
        DECODE: begin
          status <= ST_OK;
          min_q  <= '0;
          if (opcode == OP_INSERT) begin
            if (count == CAP_COUNT) begin
              status <= ST_FULL;
              state  <= RESP;
            end else if (count == '0) begin
              count <= count_t'(1);
              state <= RESP;
            end else begin
              pos   <= addr_t'(count);
              count <= count + count_t'(1);
              state <= INS_CMP;
            end
          end else begin
            if (count == '0) begin
              status <= ST_EMPTY;
              state  <= RESP;
            end else begin
              state <= EXT_LOAD;
            end
          end
        end
        INS_CMP: begin
          if (cmp_sel == SEL_LEFT) begin
            pos <= parent;
            if (parent == '0) begin
              state <= INS_FIN;
            end
          end else begin
            state <= RESP;
          end
        end
        INS_FIN: begin
          state <= RESP;
        end
        EXT_LOAD: begin
          min_q <= rdata_a;
          cur   <= rdata_b;
          count <= cnt_m1;
          pos   <= '0;
          state <= (count == count_t'(1)) ? RESP : EXT_CMP;
        end
        EXT_CMP: begin
          if (cmp_sel == SEL_CUR) begin
            state <= RESP;
          end else begin
            pos <= best;
          end
        end
        RESP: begin
          if (rsp_load) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_err_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_OK) |-> (rsp.min_key == '0 && rsp.min_handle == '0))
    else $error("error response carries a nonzero payload");

  a_count_moves_only_in_decode: assert property (@(posedge clk) disable iff (rst)
    !(state == DECODE || state == EXT_LOAD) |=> $stable(count))
    else $error("entry count changed outside decode or extract load");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_COUNT)
    else $error("entry count above capacity");

  a_hole_in_heap: assert property (@(posedge clk) disable iff (rst)
    (state == INS_CMP || state == EXT_CMP) |-> (count_t'(pos) < count))
    else $error("sift position outside the occupied heap");
`endif

endmodule

// ===== sv/binary_min_heap_priority_queue_top.sv =====
// Binary min-heap priority queue of (key, handle) pairs, CAPACITY entries.
// Insert sifts the new pair up by parent compares; extract moves the last entry
// to the root and sinks it level by level. Empty, full or first insert answer
// straight from decode. A new request is taken only once the last one has been
// through its sift walk and its response is loaded.
// Reset (rst, sync, active high) empties the heap; storage is not cleared.
module binary_min_heap_priority_queue_top (
  input  logic      clk,
  input  logic      rst,
  hpq_in_if.sink    req,
  hpq_out_if.source rsp
);
  import hpq_pkg::*;

  ram_req_t ram_req;
  entry_t   rdata_a;
  entry_t   rdata_b;
  cmp_req_t cmp_req;
  cmp_sel_e cmp_sel;

  // Sequencer: walks the heap one level per cycle and holds the response
  // register, so a new request transfer is taken while a response waits.
  hpq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .ram_req (ram_req),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b),
    .cmp_req (cmp_req),
    .cmp_sel (cmp_sel)
  );

  // The one key comparator, shared by sift-up and sift-down.
  hpq_cmp u_cmp (
    .req (cmp_req),
    .sel (cmp_sel)
  );

  // Heap array: key and handle packed into one word. Port B serves the
  // right child during sift-down and the last entry at extract start.
  hpq_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk     (clk),
    .we      (ram_req.we),
    .waddr   (ram_req.waddr),
    .wdata   (ram_req.wdata),
    .raddr_a (ram_req.raddr_a),
    .raddr_b (ram_req.raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

endmodule
